FILE: hw/rtl/bcdt_pkg.sv
// Shared types and constants for the branch coverage distance table.
package bcdt_pkg;

  localparam int unsigned EntriesDef = 1024;
  localparam int unsigned EntryW     = 10;
  localparam int unsigned HitW       = 32;
  localparam int unsigned DistW      = 14;
  localparam int unsigned CntW       = 12;
  localparam int unsigned DistInW    = 32;
  // wide enough to hold any entry index and the largest table size
  localparam int unsigned ExtW       = 17;

  localparam logic [DistW-1:0]   DistInit = DistW'(8192);
  localparam logic [HitW-1:0]    HitMax   = '1;
  localparam logic [DistInW-1:0] AbsMax   = {1'b0, {(DistInW-1){1'b1}}};

  localparam logic FuncSetup = 1'b0;
  localparam logic FuncProbe = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } st_e;

  // one table record, as stored in the memory
  typedef struct packed {
    logic             valid;
    logic             sw;
    logic [HitW-1:0]  th;
    logic [HitW-1:0]  fh;
    logic [DistW-1:0] td;
    logic [DistW-1:0] fd;
  } rec_t;

  // registered input beat
  typedef struct packed {
    logic               func;
    logic               sw_case;
    logic               taken;
    logic [DistInW-1:0] distance;
  } item_t;

  // result of one read-modify-write
  typedef struct packed {
    logic            we;
    logic            err;
    rec_t            rec;
    logic [CntW-1:0] cov;
    logic [CntW-1:0] tot;
  } upd_t;

endpackage

FILE: hw/rtl/bcdt_if.sv
// Valid/ready channel interfaces for input items and result items.
interface bcdt_in_if;
  import bcdt_pkg::*;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [EntryW-1:0]           entry;
  logic                        sw_case;
  logic                        taken;
  logic signed [DistInW-1:0]   distance;

  modport source (output valid, func, entry, sw_case, taken, distance, input ready);
  modport sink   (input valid, func, entry, sw_case, taken, distance, output ready);
endinterface

interface bcdt_out_if;
  import bcdt_pkg::*;
  logic              valid;
  logic              ready;
  logic [HitW-1:0]   true_hits;
  logic [HitW-1:0]   false_hits;
  logic [DistW-1:0]  true_distance;
  logic [DistW-1:0]  false_distance;
  logic [CntW-1:0]   covered_outcomes;
  logic [CntW-1:0]   total_outcomes;
  logic              error;

  modport source (output valid, true_hits, false_hits, true_distance, false_distance,
                  covered_outcomes, total_outcomes, error, input ready);
  modport sink   (input valid, true_hits, false_hits, true_distance, false_distance,
                  covered_outcomes, total_outcomes, error, output ready);
endinterface

FILE: hw/rtl/bcdt_mem.sv
// Record memory: one write port, one read port, registered read data.
module bcdt_mem import bcdt_pkg::*; #(
  parameter int unsigned Entries = EntriesDef,
  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  rec_t            wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output rec_t            rdata_o
);

  rec_t mem_q [Entries];
  rec_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/bcdt_update.sv
// Record update: set-up and probe rules, hit saturation, distance lowering, counts.
module bcdt_update import bcdt_pkg::*; (
  input  item_t           item_i,
  input  logic            in_range_i,
  input  rec_t            old_i,
  input  logic [CntW-1:0] cov_i,
  input  logic [CntW-1:0] tot_i,
  output upd_t            upd_o
);

  logic [DistInW-1:0] neg_d;
  logic [DistInW-1:0] abs_d;
  logic               lower_td;
  logic               lower_fd;
  logic [CntW-1:0]    cov_d;
  logic [CntW-1:0]    tot_d;

  // |distance|, the most negative value saturates
  always_comb begin
    neg_d = ~item_i.distance + DistInW'(1);
    if (!item_i.distance[DistInW-1]) begin
      abs_d = item_i.distance;
    end else if (neg_d[DistInW-1]) begin
      abs_d = AbsMax;
    end else begin
      abs_d = neg_d;
    end
  end

  assign lower_td = {{(DistInW-DistW){1'b0}}, old_i.td} > abs_d;
  assign lower_fd = {{(DistInW-DistW){1'b0}}, old_i.fd} > abs_d;

  always_comb begin
    upd_o = '0;
    cov_d = cov_i;
    tot_d = tot_i;
    if (!in_range_i) begin
      upd_o.err = 1'b1;
    end else if (item_i.func == FuncSetup) begin
      // drop the old share of a record set up before
      if (old_i.valid) begin
        tot_d = tot_d - (old_i.sw ? CntW'(1) : CntW'(2));
        if (old_i.th != '0) begin
          cov_d = cov_d - CntW'(1);
        end
        if (!old_i.sw && old_i.fh != '0) begin
          cov_d = cov_d - CntW'(1);
        end
      end
      tot_d        = tot_d + (item_i.sw_case ? CntW'(1) : CntW'(2));
      upd_o.we     = 1'b1;
      upd_o.rec    = '{valid: 1'b1, sw: item_i.sw_case, th: '0, fh: '0,
                       td: DistInit, fd: DistInit};
    end else if (!old_i.valid) begin
      upd_o.err = 1'b1;
    end else begin
      upd_o.we  = 1'b1;
      upd_o.rec = old_i;
      if (item_i.taken) begin
        if (old_i.th == '0) begin
          cov_d = cov_d + CntW'(1);
        end
        upd_o.rec.th = (old_i.th == HitMax) ? old_i.th : old_i.th + HitW'(1);
        upd_o.rec.td = '0;
        if (!old_i.sw && lower_fd) begin
          upd_o.rec.fd = abs_d[DistW-1:0];
        end
      end else begin
        if (!old_i.sw && old_i.fh == '0) begin
          cov_d = cov_d + CntW'(1);
        end
        upd_o.rec.fh = (old_i.fh == HitMax) ? old_i.fh : old_i.fh + HitW'(1);
        upd_o.rec.fd = '0;
        if (!old_i.sw && lower_td) begin
          upd_o.rec.td = abs_d[DistW-1:0];
        end
      end
    end
    upd_o.cov = cov_d;
    upd_o.tot = tot_d;
  end

endmodule

FILE: hw/rtl/branch_coverage_distance_table.sv
// Branch coverage table with branch distance: top level, sequencer and result register.
// Each item is a read-modify-write of the record memory: the record is read when the beat
// is accepted, then updated and written back in the UPDATE state, where a held result
// stalls the update. A new item is accepted only once the previous one has left UPDATE.
// Reset: counts clear at once; then a clearing pass invalidates every record, and
// in_i.ready stays low until it ends.
module branch_coverage_distance_table import bcdt_pkg::*; #(
  parameter int unsigned Entries = EntriesDef,
  localparam int unsigned IdxW   = (Entries > 1) ? $clog2(Entries) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcdt_in_if.sink     in_i,
  bcdt_out_if.source  out_o
);

  localparam logic [ExtW-1:0] EntriesExt = ExtW'(Entries);
  localparam logic [IdxW-1:0] LastIdx    = IdxW'(Entries - 1);

  // sequencer
  st_e             st_q, st_d;
  logic [IdxW-1:0] clr_q, clr_d;

  // item held for its update cycle
  item_t           item_q;
  logic [IdxW-1:0] idx_q;
  logic            in_range_q;

  // running counts
  logic [CntW-1:0] cov_q, cov_d;
  logic [CntW-1:0] tot_q, tot_d;

  // result register
  logic            out_vld_q, out_vld_d;
  upd_t            res_q;
  logic            res_load;

  // memory ports
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  rec_t            mem_wdata;
  rec_t            mem_rdata;

  logic            in_beat;
  logic [ExtW-1:0] entry_ext;
  upd_t            upd;

  assign entry_ext = {{(ExtW-EntryW){1'b0}}, in_i.entry};
  assign in_i.ready = (st_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;

  bcdt_mem #(
    .Entries (Entries)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (in_beat),
    .raddr_i (entry_ext[IdxW-1:0]),
    .rdata_o (mem_rdata)
  );

  bcdt_update u_update (
    .item_i     (item_q),
    .in_range_i (in_range_q),
    .old_i      (mem_rdata),
    .cov_i      (cov_q),
    .tot_i      (tot_q),
    .upd_o      (upd)
  );

  // next state, memory write and result load
  always_comb begin
    st_d      = st_q;
    clr_d     = clr_q;
    cov_d     = cov_q;
    tot_d     = tot_q;
    out_vld_d = out_vld_q;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = idx_q;
    mem_wdata = upd.rec;

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    case (st_q)
      ST_CLEAR: begin
        // write an invalid record to every entry
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + IdxW'(1);
        if (clr_q == LastIdx) begin
          st_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_beat) begin
          st_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // wait here while the previous result is still held
        if (!out_vld_q || out_o.ready) begin
          mem_we    = upd.we;
          cov_d     = upd.cov;
          tot_d     = upd.tot;
          res_load  = 1'b1;
          out_vld_d = 1'b1;
          st_d      = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_CLEAR;
      clr_q     <= '0;
      cov_q     <= '0;
      tot_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      clr_q     <= clr_d;
      cov_q     <= cov_d;
      tot_q     <= tot_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      item_q     <= '{func: in_i.func, sw_case: in_i.sw_case, taken: in_i.taken,
                      distance: in_i.distance};
      idx_q      <= entry_ext[IdxW-1:0];
      in_range_q <= entry_ext < EntriesExt;
    end
    if (res_load) begin
      res_q <= upd;
    end
  end

  // a rejected item reports zero record fields
  assign out_o.valid            = out_vld_q;
  assign out_o.true_hits        = res_q.err ? '0 : res_q.rec.th;
  assign out_o.false_hits       = res_q.err ? '0 : res_q.rec.fh;
  assign out_o.true_distance    = res_q.err ? '0 : res_q.rec.td;
  assign out_o.false_distance   = res_q.err ? '0 : res_q.rec.fd;
  assign out_o.covered_outcomes = res_q.cov;
  assign out_o.total_outcomes   = res_q.tot;
  assign out_o.error            = res_q.err;

endmodule

FILE: tb/bcdt_table_checker.sv
// Checker for the branch coverage distance table: record predictor and result comparison.
`timescale 1ns / 100ps

module bcdt_table_checker import bcdt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  bcdt_in_if          in_mon,
  bcdt_out_if         out_mon,
  output int unsigned mismatch_cnt_o,
  output int unsigned due_cnt_o
);

  // what one result beat should carry
  typedef struct packed {
    logic [HitW-1:0]  true_hits;
    logic [HitW-1:0]  false_hits;
    logic [DistW-1:0] true_distance;
    logic [DistW-1:0] false_distance;
    logic [CntW-1:0]  covered_outcomes;
    logic [CntW-1:0]  total_outcomes;
    logic             error;
  } rec_view_t;

  // shadow copy of the record table
  logic [HitW-1:0]  th_mem  [EntriesDef];
  logic [HitW-1:0]  fh_mem  [EntriesDef];
  logic [DistW-1:0] td_mem  [EntriesDef];
  logic [DistW-1:0] fd_mem  [EntriesDef];
  logic             sw_mem  [EntriesDef];
  bit               set_mem [EntriesDef];
  logic [CntW-1:0]  cov_cnt;
  logic [CntW-1:0]  tot_cnt;

  rec_view_t due_views[$];
  rec_view_t want;

  function automatic logic [HitW-1:0] hit_inc(logic [HitW-1:0] v);
    return (v == HitMax) ? v : v + 1'b1;
  endfunction

  // applies one item to the shadow table, returns the record as it should be reported
  function automatic rec_view_t table_update(logic func, logic [EntryW-1:0] idx, logic sw,
                                             logic tk, logic signed [DistInW-1:0] dval);
    logic [DistInW-1:0] mag;
    rec_view_t          v;
    mag = dval[DistInW-1] ? DistInW'(-dval) : DistInW'(dval);
    if (mag[DistInW-1]) mag = AbsMax;  // most negative input has no positive twin
    v = '0;
    if (func == FuncSetup) begin
      if (set_mem[idx]) begin
        // drop the old share before adding the new one
        tot_cnt = tot_cnt - (sw_mem[idx] ? CntW'(1) : CntW'(2));
        if (th_mem[idx] != '0) cov_cnt = cov_cnt - 1'b1;
        if (!sw_mem[idx] && fh_mem[idx] != '0) cov_cnt = cov_cnt - 1'b1;
      end
      set_mem[idx] = 1'b1;
      sw_mem[idx]  = sw;
      th_mem[idx]  = '0;
      fh_mem[idx]  = '0;
      td_mem[idx]  = DistInit;
      fd_mem[idx]  = DistInit;
      tot_cnt = tot_cnt + (sw ? CntW'(1) : CntW'(2));
    end else if (!set_mem[idx]) begin
      v.error = 1'b1;
    end else if (tk) begin
      if (th_mem[idx] == '0) cov_cnt = cov_cnt + 1'b1;
      th_mem[idx] = hit_inc(th_mem[idx]);
      td_mem[idx] = '0;
      if (!sw_mem[idx] && DistInW'(fd_mem[idx]) > mag) fd_mem[idx] = mag[DistW-1:0];
    end else begin
      // false side of a switch is not a counted outcome
      if (!sw_mem[idx] && fh_mem[idx] == '0) cov_cnt = cov_cnt + 1'b1;
      fh_mem[idx] = hit_inc(fh_mem[idx]);
      fd_mem[idx] = '0;
      if (!sw_mem[idx] && DistInW'(td_mem[idx]) > mag) td_mem[idx] = mag[DistW-1:0];
    end
    if (!v.error) begin
      v.true_hits      = th_mem[idx];
      v.false_hits     = fh_mem[idx];
      v.true_distance  = td_mem[idx];
      v.false_distance = fd_mem[idx];
    end
    v.covered_outcomes = cov_cnt;
    v.total_outcomes   = tot_cnt;
    return v;
  endfunction

  task automatic cmp_field(input string name, input logic [HitW-1:0] exp_v,
                           input logic [HitW-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, got_v);
      mismatch_cnt_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      foreach (set_mem[i]) set_mem[i] = 1'b0;
      cov_cnt = '0;
      tot_cnt = '0;
      due_views.delete();
    end else begin
      // result side first: a beat leaving now never belongs to one entering now
      if (out_mon.valid && out_mon.ready) begin
        if (due_views.size() == 0) begin
          $display("%0t: result beat with nothing pending: expected none, actual error=%0d",
                   $time, out_mon.error);
          mismatch_cnt_o++;
        end else begin
          want = due_views.pop_front();
          cmp_field("true_hits",        want.true_hits,        out_mon.true_hits);
          cmp_field("false_hits",       want.false_hits,       out_mon.false_hits);
          cmp_field("true_distance",    HitW'(want.true_distance),
                    HitW'(out_mon.true_distance));
          cmp_field("false_distance",   HitW'(want.false_distance),
                    HitW'(out_mon.false_distance));
          cmp_field("covered_outcomes", HitW'(want.covered_outcomes),
                    HitW'(out_mon.covered_outcomes));
          cmp_field("total_outcomes",   HitW'(want.total_outcomes),
                    HitW'(out_mon.total_outcomes));
          cmp_field("error",            HitW'(want.error),     HitW'(out_mon.error));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        due_views.push_back(table_update(in_mon.func, in_mon.entry, in_mon.sw_case,
                                         in_mon.taken, in_mon.distance));
      end
    end
    due_cnt_o = due_views.size();
  end

endmodule

FILE: tb/branch_coverage_distance_table_tb.sv
// Testbench top for the branch coverage distance table: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module branch_coverage_distance_table_tb;
  import bcdt_pkg::*;

  // random part: three idling phases of this many beats each
  localparam int unsigned PhaseBeats     = 650;
  // most random beats land on a small set of records so probes find set-up entries
  localparam int unsigned PoolSize       = 24;
  // receiver hold-off long enough to back the block up into its input
  localparam int unsigned LongHoldCycles = 300;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  bit          long_hold    = 1'b0;
  bit          hold_done    = 1'b0;

  int unsigned mismatch_cnt;
  int unsigned due_cnt;

  bcdt_in_if  in_if ();
  bcdt_out_if out_if ();

  branch_coverage_distance_table dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // watches both channels, predicts every result and counts mismatches
  bcdt_table_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_mon         (in_if),
    .out_mon        (out_if),
    .mismatch_cnt_o (mismatch_cnt),
    .due_cnt_o      (due_cnt)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // hard stop; the slowest legal run (clearing pass, one read-modify-write per item, heavy
  // idling on both sides and the long hold-off) stays well below this
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side. Ready changes only at the falling edge. When the stimulus asks for a
  // long hold-off, ready stays low for LongHoldCycles counted here, while the sender
  // keeps offering beats; the block fills and drops its input ready.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold && !hold_done) begin
        out_if.ready = 1'b0;
        repeat (LongHoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end
      out_if.ready = ($urandom_range(0, 99) >= snk_idle_pct);
    end
  end

  // One input beat. Entered and left at a falling edge. Random idle cycles go in front;
  // valid is not dropped between back-to-back beats.
  task automatic send_beat(input logic func, input logic [EntryW-1:0] idx, input logic sw,
                           input logic tk, input logic signed [DistInW-1:0] dval);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.func      = func;
    in_if.entry     = idx;
    in_if.sw_case   = sw;
    in_if.taken     = tk;
    in_if.distance  = dval;
    // ready is sampled at the rising edge, before the block updates it
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  // Random beat: mostly setups and probes on the record pool, some anywhere in the table
  // (mostly unset, so error beats). Distances mostly near the 8192 cap so that the
  // opposite-side distance really gets lowered, plus full-range values and edges.
  task automatic send_random_beat();
    logic                      func;
    logic [EntryW-1:0]         idx;
    logic                      sw;
    logic                      tk;
    logic signed [DistInW-1:0] dval;
    int unsigned               pick;
    func = ($urandom_range(0, 99) < 15) ? FuncSetup : FuncProbe;
    if ($urandom_range(0, 99) < 85) idx = EntryW'($urandom_range(0, PoolSize - 1) * 43);
    else                            idx = EntryW'($urandom);
    sw   = ($urandom_range(0, 99) < 30);
    tk   = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      dval = $urandom_range(0, 18000) - 32'd9000;
    end else if (pick < 75) begin
      dval = $urandom;
    end else begin
      case ($urandom_range(0, 7))
        0: dval = 32'sd0;
        1: dval = 32'sd1;
        2: dval = -32'sd1;
        3: dval = 32'sd8191;
        4: dval = -32'sd8192;
        5: dval = 32'sd8193;
        6: dval = 32'h7FFF_FFFF;
        default: dval = 32'h8000_0000;
      endcase
    end
    send_beat(func, idx, sw, tk, dval);
  endtask

  initial begin
    in_if.valid     = 1'b0;
    in_if.func      = FuncSetup;
    in_if.entry     = '0;
    in_if.sw_case   = 1'b0;
    in_if.taken     = 1'b0;
    in_if.distance  = '0;

    // reset once; the block then runs its clearing pass with input ready low
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // --- directed part ---
    // probe to a record never set up: error, nothing changes
    send_beat(FuncProbe, 10'd5, 1'b1, 1'b1, 32'sd7);
    // lowest and highest entries, one plain branch and one switch
    send_beat(FuncSetup, 10'd0, 1'b0, 1'b1, 32'sd0);
    send_beat(FuncSetup, 10'd1023, 1'b1, 1'b0, -32'sd1);
    send_beat(FuncProbe, 10'd0, 1'b0, 1'b1, 32'sd100);
    send_beat(FuncProbe, 10'd0, 1'b1, 1'b0, -32'sd50);
    send_beat(FuncProbe, 10'd1023, 1'b0, 1'b1, 32'h7FFF_FFFF);
    // switch record, false side: counts a hit, zeroes its distance, coverage unchanged;
    // the most negative distance rides along
    send_beat(FuncProbe, 10'd1023, 1'b0, 1'b0, 32'h8000_0000);
    send_beat(FuncProbe, 10'd1023, 1'b1, 1'b0, 32'sd3);
    // opposite-side distance: above the cap leaves it, below lowers it, then to zero
    send_beat(FuncSetup, 10'd682, 1'b0, 1'b0, 32'sd0);
    send_beat(FuncProbe, 10'd682, 1'b0, 1'b1, 32'sd9000);
    send_beat(FuncProbe, 10'd682, 1'b0, 1'b1, -32'sd8191);
    send_beat(FuncProbe, 10'd682, 1'b0, 1'b1, 32'h8000_0000);
    send_beat(FuncProbe, 10'd682, 1'b0, 1'b1, 32'sd0);
    send_beat(FuncSetup, 10'd341, 1'b0, 1'b1, 32'sd0);
    send_beat(FuncProbe, 10'd341, 1'b0, 1'b0, -32'sd8192);
    send_beat(FuncProbe, 10'd341, 1'b1, 1'b0, -32'sd1);
    send_beat(FuncProbe, 10'd341, 1'b1, 1'b1, -32'sd2147483647);
    // repeated setup: old share of total and covered counts comes out first
    send_beat(FuncSetup, 10'd0, 1'b1, 1'b0, 32'sd0);
    send_beat(FuncSetup, 10'd1023, 1'b0, 1'b1, 32'sd0);
    send_beat(FuncSetup, 10'd682, 1'b1, 1'b0, 32'sd0);
    send_beat(FuncProbe, 10'd0, 1'b0, 1'b0, 32'sd20);
    send_beat(FuncProbe, 10'd1023, 1'b0, 1'b0, 32'sd20);
    send_beat(FuncProbe, 10'd5, 1'b0, 1'b0, 32'sd0);

    // --- random part, three idling phases ---
    src_idle_pct = 26;
    snk_idle_pct = 55;
    repeat (PhaseBeats) send_random_beat();

    src_idle_pct = 55;
    snk_idle_pct = 26;
    repeat (PhaseBeats) send_random_beat();

    // no idling; starts under a long receiver hold-off
    src_idle_pct = 0;
    snk_idle_pct = 0;
    long_hold    = 1'b1;
    repeat (PhaseBeats) send_random_beat();

    in_if.valid = 1'b0;

    // drain, then wait on to catch stray result beats
    while (due_cnt != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);

    if (mismatch_cnt == 0 && due_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: branch_coverage_distance_table.f
hw/rtl/bcdt_pkg.sv
hw/rtl/bcdt_if.sv
hw/rtl/bcdt_mem.sv
hw/rtl/bcdt_update.sv
hw/rtl/branch_coverage_distance_table.sv
tb/bcdt_table_checker.sv
tb/branch_coverage_distance_table_tb.sv
